// ===== sv/dcr_pkg.sv =====
`default_nettype none
package dcr_pkg;

	// Block size, frame slots and ADC resolution
	localparam int HALF_LEN    = 512;
	localparam int FRAMES      = 4;
	localparam int SAMPLE_BITS = 12;

	// Fixed field widths of the stream items
	localparam int IN_FIELD_W  = 12;
	localparam int CENTER_W    = 22;
	localparam int FRAME_OUT_W = 2;
	localparam int POS_OUT_W   = 9;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 56;

	// Derived internal widths
	localparam int POS_W   = (HALF_LEN > 1) ? $clog2(HALF_LEN) : 1;
	localparam int ADDR_W  = $clog2(2 * HALF_LEN);
	localparam int DEPTH   = 2 * HALF_LEN;
	localparam int SUM_W   = SAMPLE_BITS + POS_W;
	localparam int CALC_W  = SUM_W + 1;
	localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	// One stored I/Q pair, I in the low bits
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] q;
		logic [SAMPLE_BITS-1:0] i;
	} pair_t;

	// Store access for one item: write the new pair, read the old one
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		pair_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} store_req_t;

endpackage
`default_nettype wire

// ===== sv/dcr_store.sv =====
`default_nettype none
module dcr_store (
	input  wire logic               clk,
	input  dcr_pkg::store_req_t     req,
	output dcr_pkg::pair_t          rdata
);
	import dcr_pkg::*;

	// Ping-pong banks: entries 0..HALF_LEN-1 are bank 0, the rest bank 1
	pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/iq_block_dc_removal_unit.sv =====
`default_nettype none
// I/Q block DC offset removal. Each input item is one I/Q ADC pair; pairs
// fill ping-pong banks of HALF_LEN entries while I and Q are summed. Once a
// block is full, every new pair releases the pair at the same position of
// the previous block as HALF_LEN*x minus that block's sum, i.e. the mean-
// removed value with log2(HALF_LEN) fraction bits, tagged with a frame slot
// (wraps after FRAMES), its position, and tlast on the block's last pair.
// The first HALF_LEN items give no results and the last block is never
// flushed. Rate: one item per clock while the output is not stalled; the
// store has one write and one read port and each item uses one of each in
// its accept cycle. A result passes the store read register, then the
// output register. The store needs no clearing after reset.
module iq_block_dc_removal_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [11:0] i_sample, [23:12] q_sample
	input  wire logic [dcr_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [21:0] i_centered, [43:22] q_centered, [45:44] frame_number,
	// [54:46] sample_position, [55] zero
	output logic [dcr_pkg::OUT_DATA_W-1:0]          m_tdata,
	// block_end
	output logic                                    m_tlast
);
	import dcr_pkg::*;

	// Fill side state
	logic [POS_W-1:0]   pos_q;
	logic               bank_q;
	logic [SUM_W-1:0]   run_i_q, run_q_q;
	logic [SUM_W-1:0]   held_i_q, held_q_q;
	logic               prev_ready_q;
	logic [FRAME_W-1:0] frame_q;

	// Stage 1: store read in flight
	logic               v_s1;
	logic [SUM_W-1:0]   held_i_s1, held_q_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [POS_W-1:0]   pos_s1;
	logic               last_s1;

	logic       out_en, s1_en, accept, pos_last, release_item;
	pair_t      new_pair, old_pair;
	store_req_t req;
	logic [ADDR_W-1:0] fill_addr, prev_addr;

	// Pipeline advance: output moves when empty or taken, stage 1 when
	// empty or moving on
	assign out_en   = !m_tvalid || m_tready;
	assign s1_en    = !v_s1 || out_en;
	assign s_tready = s1_en;
	assign accept   = s_tvalid && s_tready;

	assign pos_last     = (pos_q == POS_W'(HALF_LEN - 1));
	assign release_item = accept && prev_ready_q;

	assign new_pair.i = SAMPLE_BITS'(s_tdata[IN_FIELD_W-1:0]);
	assign new_pair.q = SAMPLE_BITS'(s_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);

	assign fill_addr = bank_q ? (ADDR_W'(pos_q) + ADDR_W'(HALF_LEN)) : ADDR_W'(pos_q);
	assign prev_addr = bank_q ? ADDR_W'(pos_q) : (ADDR_W'(pos_q) + ADDR_W'(HALF_LEN));

	assign req.we    = accept;
	assign req.waddr = fill_addr;
	assign req.wdata = new_pair;
	assign req.re    = accept;
	assign req.raddr = prev_addr;

	dcr_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (old_pair)
	);

	// Block fill, sums and frame slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			bank_q       <= 1'b0;
			run_i_q      <= '0;
			run_q_q      <= '0;
			held_i_q     <= '0;
			held_q_q     <= '0;
			prev_ready_q <= 1'b0;
			frame_q      <= '0;
		end else if (accept) begin
			if (pos_last) begin
				// block complete: hold its sums, swap banks
				held_i_q     <= run_i_q + SUM_W'(new_pair.i);
				held_q_q     <= run_q_q + SUM_W'(new_pair.q);
				run_i_q      <= '0;
				run_q_q      <= '0;
				prev_ready_q <= 1'b1;
				bank_q       <= !bank_q;
				pos_q        <= '0;
			end else begin
				run_i_q <= run_i_q + SUM_W'(new_pair.i);
				run_q_q <= run_q_q + SUM_W'(new_pair.q);
				pos_q   <= pos_q + POS_W'(1);
			end
			if (prev_ready_q && pos_last) begin
				frame_q <= (frame_q == FRAME_W'(FRAMES - 1)) ? '0 : frame_q + FRAME_W'(1);
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= release_item;
		end
	end

	// Stage 1 payload, captured with the store read
	always_ff @(posedge clk) begin
		if (accept) begin
			held_i_s1 <= held_i_q;
			held_q_s1 <= held_q_q;
			frame_s1  <= frame_q;
			pos_s1    <= pos_q;
			last_s1   <= pos_last;
		end
	end

	// Centering: HALF_LEN*x - block sum, wrapped to the output width
	logic [SUM_W-1:0]         prod_i, prod_q;
	logic signed [CALC_W-1:0] diff_i, diff_q;

	assign prod_i = SUM_W'(old_pair.i * HALF_LEN);
	assign prod_q = SUM_W'(old_pair.q * HALF_LEN);
	assign diff_i = $signed({1'b0, prod_i}) - $signed({1'b0, held_i_s1});
	assign diff_q = $signed({1'b0, prod_q}) - $signed({1'b0, held_q_s1});

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_en) begin
			m_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s1) begin
			m_tdata <= {1'b0, POS_OUT_W'(pos_s1), FRAME_OUT_W'(frame_s1),
				CENTER_W'(diff_q), CENTER_W'(diff_i)};
			m_tlast <= last_s1;
		end
	end

`ifndef NO_ASSERTIONS
	// fill position always inside the block
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(HALF_LEN - 1))
		else $error("fill position beyond block");

	// frame slot stays below FRAMES
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q <= FRAME_W'(FRAMES - 1))
		else $error("frame slot out of range");

	// a released item only exists once a full block was held
	a_release_ready: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> prev_ready_q)
		else $error("release before first full block");

	// a stalled stage 1 keeps its item and takes no new one
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_en |=> v_s1 && $stable(pos_s1) && !$past(accept))
		else $error("stage 1 item lost under stall");
`endif

endmodule
`default_nettype wire

// ===== dv/iq_block_dc_removal_unit_tb.sv =====
module iq_block_dc_removal_unit_tb;
	import dcr_pkg::*;

	// m_tdata field offsets, lowest field first
	localparam int I_LSB     = 0;
	localparam int Q_LSB     = I_LSB + CENTER_W;
	localparam int FRAME_LSB = Q_LSB + CENTER_W;
	localparam int POS_LSB   = FRAME_LSB + FRAME_OUT_W;
	localparam int PAD_LSB   = POS_LSB + POS_OUT_W;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	// sender-side sample shapes; the last two hold for a whole block
	typedef enum int {
		STYLE_UNIFORM,
		STYLE_RAILS,
		STYLE_SPIKE,
		STYLE_NEAR_TOP,
		STYLE_NEAR_BOTTOM,
		STYLE_ALL_TOP,
		STYLE_ALL_BOTTOM
	} sample_style_e;

	// receiver stall shapes
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_MOSTLY,
		RX_ONE_IN_FOUR
	} rx_style_e;

	// one expected output item
	typedef struct packed {
		logic [CENTER_W-1:0]    i_c;
		logic [CENTER_W-1:0]    q_c;
		logic [FRAME_OUT_W-1:0] frame;
		logic [POS_OUT_W-1:0]   pos;
		logic                   last;
	} centered_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	iq_block_dc_removal_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Mean-removal predictor: own copy of the ping-pong banks and sums.
	// ------------------------------------------------------------------
	pair_t            bank_mem [DEPTH];
	int unsigned      fill_pos = 0;
	int unsigned      fill_bank = 0;
	logic [SUM_W-1:0] fill_sum_i = '0;
	logic [SUM_W-1:0] fill_sum_q = '0;
	logic [SUM_W-1:0] held_sum_i = '0;
	logic [SUM_W-1:0] held_sum_q = '0;
	logic             block_ready = 1'b0;
	int unsigned      frame_slot = 0;

	centered_item_t   pending_centered [$];
	int               mismatch_count = 0;
	int               result_count = 0;

	// HALF_LEN*x - sum, wrapped to the output width (two's complement)
	function automatic logic [CENTER_W-1:0] center_sample(logic [SAMPLE_BITS-1:0] x,
			logic [SUM_W-1:0] s);
		longint v;
		v = longint'(HALF_LEN) * longint'(x) - longint'(s);
		return CENTER_W'(v);
	endfunction

	// Advance the predictor by one accepted pair; queue the released result.
	task automatic remove_block_mean(input logic [SAMPLE_BITS-1:0] xi,
			input logic [SAMPLE_BITS-1:0] xq);
		pair_t          old;
		centered_item_t r;
		if (block_ready) begin
			// same position of the other (full) bank
			old     = bank_mem[(fill_bank ^ 1) * HALF_LEN + fill_pos];
			r.i_c   = center_sample(old.i, held_sum_i);
			r.q_c   = center_sample(old.q, held_sum_q);
			r.frame = FRAME_OUT_W'(frame_slot);
			r.pos   = POS_OUT_W'(fill_pos);
			r.last  = (fill_pos == HALF_LEN - 1);
			pending_centered.push_back(r);
			if (r.last) begin
				frame_slot = (frame_slot + 1 >= FRAMES) ? 0 : frame_slot + 1;
			end
		end
		bank_mem[fill_bank * HALF_LEN + fill_pos] = {xq, xi};
		fill_sum_i += xi;
		fill_sum_q += xq;
		fill_pos++;
		if (fill_pos >= HALF_LEN) begin
			// block complete: hold its sums, swap banks
			held_sum_i  = fill_sum_i;
			held_sum_q  = fill_sum_q;
			fill_sum_i  = '0;
			fill_sum_q  = '0;
			block_ready = 1'b1;
			fill_bank  ^= 1;
			fill_pos    = 0;
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("MISMATCH t=%0t result #%0d %s: got 0x%0h, want 0x%0h",
				$time, result_count, what, got, want);
		end
	endtask

	task automatic compare_field(string what, longint unsigned got, longint unsigned want);
		if (got != want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// output items are taken at the edge where tvalid and tready are both high
	always @(posedge clk) begin : result_check
		centered_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_centered.size() == 0) begin
				report_mismatch("item with none expected", m_tdata, 0);
			end else begin
				want = pending_centered.pop_front();
				compare_field("i_centered", m_tdata[I_LSB +: CENTER_W], want.i_c);
				compare_field("q_centered", m_tdata[Q_LSB +: CENTER_W], want.q_c);
				compare_field("frame_number", m_tdata[FRAME_LSB +: FRAME_OUT_W], want.frame);
				compare_field("sample_position", m_tdata[POS_LSB +: POS_OUT_W], want.pos);
				compare_field("tdata pad", m_tdata[OUT_DATA_W-1:PAD_LSB], 0);
				compare_field("block_end", m_tlast, want.last);
			end
			result_count++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: own stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------
	int        rx_hold_len = 0;
	rx_style_e rx_style = RX_ALWAYS;
	int        rx_left = 0;
	int        rx_phase = 0;

	initial begin : rx_pattern
		forever begin
			@(posedge clk);
			if (rx_hold_len != 0) begin
				// hold-off counted here so the sender keeps pushing meanwhile
				m_tready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
			end
			if (rx_left == 0) begin
				rx_style = rx_style_e'($urandom_range(RX_ALWAYS, RX_ONE_IN_FOUR));
				rx_left  = $urandom_range(32, 256);
			end
			rx_left--;
			rx_phase++;
			case (rx_style)
				RX_ALWAYS:      m_tready <= 1'b1;
				RX_COIN:        m_tready <= ($urandom_range(0, 1) == 1);
				RX_MOSTLY:      m_tready <= ($urandom_range(0, 7) != 0);
				RX_ONE_IN_FOUR: m_tready <= (rx_phase % 4 == 0);
				default:        m_tready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sender: bursts of random length separated by random gaps
	// ------------------------------------------------------------------
	int            burst_left = 0;
	logic          sender_gaps = 1'b1;
	sample_style_e chunk_style = STYLE_UNIFORM;
	logic          flat_block = 1'b0;

	task automatic sender_idle(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offer one pair and wait for it to be taken. tvalid stays high on return;
	// anything that then waits must go through sender_idle first.
	task automatic send_pair(input logic [SAMPLE_BITS-1:0] xi,
			input logic [SAMPLE_BITS-1:0] xq);
		if (burst_left == 0) begin
			if (sender_gaps) begin
				sender_idle($urandom_range(1, 12));
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({xq, xi});
		do @(posedge clk); while (!s_tready);
		remove_block_mean(xi, xq);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] draw_sample(sample_style_e s);
		case (s)
			STYLE_RAILS:       return ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : '0;
			STYLE_SPIKE:       return ($urandom_range(0, 31) == 0) ? SAMPLE_MAX
				: SAMPLE_BITS'($urandom_range(0, 15));
			STYLE_NEAR_TOP:    return SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 63));
			STYLE_NEAR_BOTTOM: return SAMPLE_BITS'($urandom_range(0, 63));
			STYLE_ALL_TOP:     return SAMPLE_MAX;
			STYLE_ALL_BOTTOM:  return '0;
			default:           return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
		endcase
	endfunction

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_centered.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes and alternating bit patterns. These land in the first
	// block, so nothing may come out yet; they come back centered later.
	task automatic test_range_extremes();
		send_pair('0, '0);
		send_pair(SAMPLE_MAX, SAMPLE_MAX);
		send_pair('0, SAMPLE_MAX);
		send_pair(SAMPLE_MAX, '0);
		send_pair(12'hAAA, 12'h555);
		send_pair(12'h555, 12'hAAA);
		send_pair(12'h001, 12'h800);
		send_pair(12'h800, 12'h001);
		send_pair(SAMPLE_MAX, SAMPLE_MAX - 1);
		send_pair(12'h001, '0);
	endtask

	// Random stream. Some whole blocks are flat at either rail (sum at its
	// extremes, centered values all zero); the rest switch shape every 64 pairs.
	task automatic test_mixed_stream(input int n);
		int pick;
		for (int k = 0; k < n; k++) begin
			if (fill_pos == 0) begin
				pick       = $urandom_range(0, 5);
				flat_block = (pick < 2);
				if (pick == 0) chunk_style = STYLE_ALL_TOP;
				if (pick == 1) chunk_style = STYLE_ALL_BOTTOM;
			end
			if (!flat_block && fill_pos % 64 == 0) begin
				chunk_style = sample_style_e'($urandom_range(STYLE_UNIFORM, STYLE_NEAR_BOTTOM));
			end
			send_pair(draw_sample(chunk_style), draw_sample(chunk_style));
		end
	endtask

	// Long receiver hold-off while the sender pushes with no gaps, so the
	// output path fills and s_tready must drop.
	task automatic test_output_backpressure();
		sender_gaps = 1'b0;
		burst_left  = 400;
		rx_hold_len = 400;
		test_mixed_stream(300);
		sender_gaps = 1'b1;
	endtask

	// Sender stops until every released item has arrived, then resumes.
	task automatic test_drain_pause();
		test_mixed_stream(150);
		wait_results_drained();
		sender_idle(6);
		test_mixed_stream(150);
	endtask

	// ------------------------------------------------------------------
	// Main sequence. Ends mid-block: the last full block is only partly
	// released and nothing beyond the predicted items may appear.
	// ------------------------------------------------------------------
	initial begin : main_seq
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_range_extremes();
		test_mixed_stream(600);
		test_output_backpressure();
		test_drain_pause();
		test_mixed_stream(40);

		s_tvalid <= 1'b0;
		for (int n = 0; n < 20000 && pending_centered.size() != 0; n++) @(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_centered.size() != 0) begin
			report_mismatch("items never delivered", pending_centered.size(), 0);
		end
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// hang guard, well above the slowest legal run
	initial begin : run_limit
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/dcr_pkg.sv
sv/dcr_store.sv
sv/iq_block_dc_removal_unit.sv
dv/iq_block_dc_removal_unit_tb.sv
